/* hw/rtl/bnm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnm_pkg
// Shared types and constants for the blob neighbor mask tile lookup.
// ----------------------------------------------------------------------------
package bnm_pkg;

   localparam int TILE_W      = 10;   // width of a tile id field
   localparam int MASK_W      = 8;    // neighbor mask width
   localparam int DIR_COUNT   = 8;    // n ne e se s sw w nw
   localparam int TABLE_DEPTH = 256;
   localparam logic [MASK_W-1:0] FULL_MASK = 8'hFF;

   typedef enum logic [2:0] {
      OP_MEMBER    = 3'd0,
      OP_TABLE_WR  = 3'd1,
      OP_TABLE_INV = 3'd2,
      OP_COMPUTE   = 3'd3
   } op_type;

   // membership bit update
   typedef struct packed {
      logic              en;
      logic [TILE_W-1:0] id;
      logic              flag;
   } member_wr_type;

   // table entry write or invalidate
   typedef struct packed {
      logic              wr;
      logic              inv;
      logic [MASK_W-1:0] idx;
      logic [TILE_W-1:0] tile;
   } table_wr_type;

endpackage

/* hw/rtl/bnm_member_lookup.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnm_member_lookup
// Membership bit store, one copy per neighbor direction so all eight ids are
// looked up at once. Cleared by a sweep after reset.
// ----------------------------------------------------------------------------
module bnm_member_lookup #(
   parameter int TILE_ID_BITS = 10
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  bnm_pkg::member_wr_type                     member_wr,
   input  logic                                       rd_en,
   input  logic [bnm_pkg::DIR_COUNT-1:0][bnm_pkg::TILE_W-1:0] rd_ids,
   output logic [bnm_pkg::DIR_COUNT-1:0]              member_q,
   output logic                                       clr_busy
);

   localparam int DEPTH = 1 << TILE_ID_BITS;

   logic [TILE_ID_BITS-1:0] clr_cnt_ff, clr_cnt_in;
   logic                    clr_busy_ff, clr_busy_in;
   logic [TILE_ID_BITS-1:0] wr_addr;
   logic                    wr_data;
   logic                    wr_en;

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_cnt_in  = clr_cnt_ff;
      if (clr_busy_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == '1) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_cnt_ff  <= clr_cnt_in;
      end
   end

   // sweep owns the write port while busy
   assign wr_en   = clr_busy_ff || member_wr.en;
   assign wr_addr = clr_busy_ff ? clr_cnt_ff : TILE_ID_BITS'(member_wr.id);
   assign wr_data = clr_busy_ff ? 1'b0 : member_wr.flag;

   for (genvar k = 0; k < bnm_pkg::DIR_COUNT; k++) begin : g_copy
      logic bits_ff [DEPTH];
      logic rd_ff;

      always_ff @(posedge clock) begin
         if (wr_en) begin
            bits_ff[wr_addr] <= wr_data;
         end
      end

      always_ff @(posedge clock) begin
         if (rd_en) begin
            rd_ff <= bits_ff[TILE_ID_BITS'(rd_ids[k])];
         end
      end

      assign member_q[k] = rd_ff;
   end

   assign clr_busy = clr_busy_ff;

endmodule

/* hw/rtl/bnm_mask_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnm_mask_table
// Mask to replacement tile table with per-entry valid bits and a dedicated
// copy of the full-mask entry used as fallback.
// ----------------------------------------------------------------------------
module bnm_mask_table (
   input  logic                          clock,
   input  logic                          reset,
   input  bnm_pkg::table_wr_type         table_wr,
   input  logic                          rd_en,
   input  logic [bnm_pkg::MASK_W-1:0]    rd_mask,
   output logic [bnm_pkg::TILE_W-1:0]    tile_q,
   output logic                          found_q
);

   logic [bnm_pkg::TILE_W-1:0] table_ff [bnm_pkg::TABLE_DEPTH];
   logic [bnm_pkg::TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic [bnm_pkg::TILE_W-1:0] full_tile_ff;

   logic [bnm_pkg::TILE_W-1:0] rd_tile_ff;
   logic                       rd_valid_ff;
   logic [bnm_pkg::TILE_W-1:0] rd_full_tile_ff;
   logic                       rd_full_valid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (table_wr.wr) begin
         valid_in[table_wr.idx] = 1'b1;
      end else if (table_wr.inv) begin
         valid_in[table_wr.idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (table_wr.wr) begin
         table_ff[table_wr.idx] <= table_wr.tile;
      end
   end

   always_ff @(posedge clock) begin
      if (table_wr.wr && table_wr.idx == bnm_pkg::FULL_MASK) begin
         full_tile_ff <= table_wr.tile;
      end
   end

   // read sees state from before any write on the same edge
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_tile_ff       <= table_ff[rd_mask];
         rd_valid_ff      <= valid_ff[rd_mask];
         rd_full_tile_ff  <= full_tile_ff;
         rd_full_valid_ff <= valid_ff[bnm_pkg::FULL_MASK];
      end
   end

   always_comb begin
      if (rd_valid_ff) begin
         tile_q  = rd_tile_ff;
         found_q = 1'b1;
      end else if (rd_full_valid_ff) begin
         tile_q  = rd_full_tile_ff;
         found_q = 1'b1;
      end else begin
         tile_q  = '0;
         found_q = 1'b0;
      end
   end

endmodule

/* hw/rtl/blob_neighbor_mask_tile_lookup.sv */
`timescale 1ns / 1ps
// Path: a compute beat goes through stage A, stage B and the response register.
// Throughput: one beat per cycle unless stalled; load beats produce no response.
// Rate is set by the eight member-bit copies (one read port each) and the
//   single read port of the mask table, each used once per beat.
// Reset: synchronous; table valid bits clear at once, then a sweep clears the
//   member bits of all 2**TILE_ID_BITS ids (1024 by default), req_ready low.
// ----------------------------------------------------------------------------
// blob_neighbor_mask_tile_lookup
// Blob autotile lookup: builds the 8-neighbor mask from group membership and
// maps it to a replacement tile, falling back to the full-mask entry.
// ----------------------------------------------------------------------------
module blob_neighbor_mask_tile_lookup #(
   parameter int TILE_ID_BITS = 10
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [2:0]                          req_operation,
   input  logic [bnm_pkg::TILE_W-1:0]          req_load_index,
   input  logic [bnm_pkg::TILE_W-1:0]          req_load_value,
   input  logic [bnm_pkg::MASK_W-1:0]          req_in_bounds,
   input  logic [bnm_pkg::TILE_W-1:0]          req_north,
   input  logic [bnm_pkg::TILE_W-1:0]          req_north_east,
   input  logic [bnm_pkg::TILE_W-1:0]          req_east,
   input  logic [bnm_pkg::TILE_W-1:0]          req_south_east,
   input  logic [bnm_pkg::TILE_W-1:0]          req_south,
   input  logic [bnm_pkg::TILE_W-1:0]          req_south_west,
   input  logic [bnm_pkg::TILE_W-1:0]          req_west,
   input  logic [bnm_pkg::TILE_W-1:0]          req_north_west,

   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [bnm_pkg::MASK_W-1:0]          rsp_mask,
   output logic [bnm_pkg::TILE_W-1:0]          rsp_chosen_tile,
   output logic                                rsp_tile_found
);

   // replacement ids are kept to TILE_ID_BITS, then to the field width
   localparam logic [bnm_pkg::TILE_W-1:0] TILE_VAL_MASK =
      bnm_pkg::TILE_W'((64'd1 << TILE_ID_BITS) - 64'd1);

   // corner counts only with both adjacent edges
   function automatic logic [bnm_pkg::MASK_W-1:0] form_mask(
      input logic [bnm_pkg::MASK_W-1:0] p
   );
      logic n, e, s, w;
      n = p[0];
      e = p[2];
      s = p[4];
      w = p[6];
      return {p[7] & n & w, w, p[5] & s & w, s, p[3] & s & e, e, p[1] & n & e, n};
   endfunction

   bnm_pkg::member_wr_type member_wr;
   bnm_pkg::table_wr_type  table_wr;
   logic [bnm_pkg::DIR_COUNT-1:0][bnm_pkg::TILE_W-1:0] ids;
   logic [bnm_pkg::DIR_COUNT-1:0] member_q;
   logic clr_busy;

   logic accept, is_compute;
   logic a_adv, b_adv, a_load;

   // stage A: member bits in flight
   logic                       a_vld_ff, a_vld_in;
   logic [bnm_pkg::MASK_W-1:0] a_bounds_ff;
   logic [bnm_pkg::MASK_W-1:0] a_mask;
   // stage B: table read data in flight
   logic                       b_vld_ff, b_vld_in;
   logic [bnm_pkg::MASK_W-1:0] b_mask_ff;
   logic [bnm_pkg::TILE_W-1:0] b_tile;
   logic                       b_found;
   // response register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [bnm_pkg::MASK_W-1:0] rsp_mask_ff;
   logic [bnm_pkg::TILE_W-1:0] rsp_tile_ff;
   logic                       rsp_found_ff;

   assign ids = {req_north_west, req_west, req_south_west, req_south,
                 req_south_east, req_east, req_north_east, req_north};

   // --- handshake / stage advance -------------------------------------------
   assign b_adv     = !rsp_valid_ff || rsp_ready;
   assign a_adv     = !b_vld_ff || b_adv;
   assign a_load    = !a_vld_ff || a_adv;
   assign req_ready = !clr_busy && a_load;
   assign accept    = req_valid && req_ready;

   // --- operation decode ----------------------------------------------------
   always_comb begin
      member_wr  = '0;
      table_wr   = '0;
      is_compute = 1'b0;
      member_wr.id   = req_load_index;
      member_wr.flag = req_load_value[0];
      table_wr.idx   = req_load_index[bnm_pkg::MASK_W-1:0];
      table_wr.tile  = req_load_value & TILE_VAL_MASK;
      unique case (bnm_pkg::op_type'(req_operation))
         bnm_pkg::OP_MEMBER: begin
            member_wr.en = accept;
         end
         bnm_pkg::OP_TABLE_WR: begin
            // indexes past the table are dropped
            table_wr.wr = accept &&
                          (req_load_index[bnm_pkg::TILE_W-1:bnm_pkg::MASK_W] == '0);
         end
         bnm_pkg::OP_TABLE_INV: begin
            table_wr.inv = accept &&
                           (req_load_index[bnm_pkg::TILE_W-1:bnm_pkg::MASK_W] == '0);
         end
         bnm_pkg::OP_COMPUTE: begin
            is_compute = 1'b1;
         end
         default: begin
            // unused codes are consumed silently
         end
      endcase
   end

   // --- member lookup: accept edge reads all eight ids ----------------------
   bnm_member_lookup #(
      .TILE_ID_BITS (TILE_ID_BITS)
   ) u_member (
      .clock     (clock),
      .reset     (reset),
      .member_wr (member_wr),
      .rd_en     (accept && is_compute),
      .rd_ids    (ids),
      .member_q  (member_q),
      .clr_busy  (clr_busy)
   );

   always_ff @(posedge clock) begin
      if (accept && is_compute) begin
         a_bounds_ff <= req_in_bounds;
      end
   end

   assign a_mask = form_mask(member_q & a_bounds_ff);

   // --- table lookup on A -> B ----------------------------------------------
   bnm_mask_table u_table (
      .clock    (clock),
      .reset    (reset),
      .table_wr (table_wr),
      .rd_en    (a_adv && a_vld_ff),
      .rd_mask  (a_mask),
      .tile_q   (b_tile),
      .found_q  (b_found)
   );

   always_ff @(posedge clock) begin
      if (a_adv && a_vld_ff) begin
         b_mask_ff <= a_mask;
      end
   end

   // --- response register ---------------------------------------------------
   always_ff @(posedge clock) begin
      if (b_adv && b_vld_ff) begin
         rsp_mask_ff  <= b_mask_ff;
         rsp_tile_ff  <= b_tile;
         rsp_found_ff <= b_found;
      end
   end

   // --- stage valids --------------------------------------------------------
   always_comb begin
      a_vld_in     = a_load ? (accept && is_compute) : a_vld_ff;
      b_vld_in     = a_adv ? a_vld_ff : b_vld_ff;
      rsp_valid_in = b_adv ? b_vld_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff     <= 1'b0;
         b_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_vld_ff     <= a_vld_in;
         b_vld_ff     <= b_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_mask        = rsp_mask_ff;
   assign rsp_chosen_tile = rsp_tile_ff;
   assign rsp_tile_found  = rsp_found_ff;

   // --- assertions ----------------------------------------------------------
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      clr_busy |-> !req_ready)
      else $error("beat accepted during member clear sweep");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_tile_found |-> rsp_chosen_tile == '0)
      else $error("tile nonzero when not found");

   a_corner_needs_edges: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !((rsp_mask[1] && !(rsp_mask[0] && rsp_mask[2])) ||
                      (rsp_mask[3] && !(rsp_mask[4] && rsp_mask[2])) ||
                      (rsp_mask[5] && !(rsp_mask[4] && rsp_mask[6])) ||
                      (rsp_mask[7] && !(rsp_mask[0] && rsp_mask[6]))))
      else $error("corner bit set without both adjacent edges");

   a_pipe_order: assert property (@(posedge clock) disable iff (reset)
      b_vld_ff && !b_adv |=> b_vld_ff && $stable(b_mask_ff))
      else $error("stalled table stage lost its beat");

endmodule

/* tb/tb_blob_neighbor_mask_tile_lookup.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_blob_neighbor_mask_tile_lookup
// Self-checking bench for the blob autotile lookup. Request beats load group
// membership and the mask-to-tile map, or ask for a neighbor lookup. A shadow
// copy of both stores predicts every response, which is compared field by
// field. Runs directed corner cases, then random traffic under four idling
// phases, with one long response back-pressure stretch.
// ----------------------------------------------------------------------------
module tb_blob_neighbor_mask_tile_lookup;

   localparam int TILE_W       = bnm_pkg::TILE_W;
   localparam int MASK_W       = bnm_pkg::MASK_W;
   localparam int DIR_COUNT    = bnm_pkg::DIR_COUNT;
   localparam int TABLE_DEPTH  = bnm_pkg::TABLE_DEPTH;

   localparam int CLK_HALF_NS  = 6;        // 12 ns period
   localparam int RESET_CYCLES = 11;
   localparam int RANDOM_BEATS = 250;      // per idling phase, ignored codes excluded
   localparam int LONG_HOLD    = 200;      // response stall that backs up the pipe
   localparam int TAIL_CYCLES  = 12;       // pipe is 3 deep, leave some margin
   localparam int CYCLE_LIMIT  = 200000;   // member sweep + slow phases, many times over
   localparam int PRINT_CAP    = 200;
   localparam int TILE_COUNT   = 1 << TILE_W;

   // full-mask entry as a load index
   localparam logic [TILE_W-1:0] FULL_IDX = TILE_W'(bnm_pkg::FULL_MASK);

   // codes the block has to ignore
   localparam logic [2:0] OP_SPARE_FIRST = 3'd4;
   localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

   // one request beat; nbr index matches the in_bounds bit (n ne e se s sw w nw)
   typedef struct packed {
      logic [2:0]                       op;
      logic [TILE_W-1:0]                load_index;
      logic [TILE_W-1:0]                load_value;
      logic [MASK_W-1:0]                in_bounds;
      logic [DIR_COUNT-1:0][TILE_W-1:0] nbr;
   } tile_req_type;

   typedef struct packed {
      logic [MASK_W-1:0] mask;
      logic [TILE_W-1:0] tile;
      logic              found;
   } tile_rsp_type;

   // -------------------------------------------------------------------------
   // Shadow of membership bits and the mask map; queue of pending lookups.
   // -------------------------------------------------------------------------
   class tile_lookup_scoreboard;
      bit                member[TILE_COUNT];
      logic [TILE_W-1:0] tile_map[TABLE_DEPTH];
      bit                map_valid[TABLE_DEPTH];
      tile_rsp_type      expected_q[$];
      int unsigned       mismatches, beats, lookups, hits_exact, hits_fallback, misses;

      function void note_request(tile_req_type b);
         bit           here[DIR_COUNT];
         tile_rsp_type r;
         beats++;
         case (b.op)
            bnm_pkg::OP_MEMBER: begin
               member[b.load_index] = b.load_value[0];
            end
            bnm_pkg::OP_TABLE_WR: begin
               if (b.load_index < TABLE_DEPTH) begin
                  tile_map[b.load_index]  = b.load_value;
                  map_valid[b.load_index] = 1'b1;
               end
            end
            bnm_pkg::OP_TABLE_INV: begin
               // stored tile is kept, only the valid bit drops
               if (b.load_index < TABLE_DEPTH)
                  map_valid[b.load_index] = 1'b0;
            end
            bnm_pkg::OP_COMPUTE: begin
               for (int d = 0; d < DIR_COUNT; d++)
                  here[d] = b.in_bounds[d] && member[b.nbr[d]];
               r = '0;
               for (int d = 0; d < DIR_COUNT; d += 2)
                  r.mask[d] = here[d];
               // corner needs both flanking edges present
               for (int d = 1; d < DIR_COUNT; d += 2)
                  r.mask[d] = here[d] && here[d-1] && here[(d+1) % DIR_COUNT];
               if (map_valid[r.mask]) begin
                  r.tile  = tile_map[r.mask];
                  r.found = 1'b1;
                  hits_exact++;
               end else if (map_valid[bnm_pkg::FULL_MASK]) begin
                  r.tile  = tile_map[bnm_pkg::FULL_MASK];
                  r.found = 1'b1;
                  hits_fallback++;
               end else begin
                  misses++;
               end
               expected_q = {expected_q, r};
            end
            default: ;
         endcase
      endfunction

      task report_mismatch(string what, logic [31:0] got_v, logic [31:0] want_v);
         mismatches++;
         if (mismatches <= PRINT_CAP)
            $display("[%0t ns] mismatch on %s: got 0x%0h, want 0x%0h",
                     $time, what, got_v, want_v);
      endtask

      task check_response(tile_rsp_type got);
         tile_rsp_type want;
         if (expected_q.size() == 0) begin
            report_mismatch("response with no lookup pending", 32'(got), 32'd0);
            return;
         end
         want = expected_q.pop_front();
         lookups++;
         if (got.mask !== want.mask)
            report_mismatch("mask", 32'(got.mask), 32'(want.mask));
         if (got.tile !== want.tile)
            report_mismatch("chosen_tile", 32'(got.tile), 32'(want.tile));
         if (got.found !== want.found)
            report_mismatch("tile_found", 32'(got.found), 32'(want.found));
      endtask
   endclass

   // -------------------------------------------------------------------------
   // DUT hookup. Every input starts at a known value.
   // -------------------------------------------------------------------------
   logic              clock           = 1'b0;
   logic              reset           = 1'b1;
   logic              req_valid       = 1'b0;
   logic              req_ready;
   logic [2:0]        req_operation   = '0;
   logic [TILE_W-1:0] req_load_index  = '0;
   logic [TILE_W-1:0] req_load_value  = '0;
   logic [MASK_W-1:0] req_in_bounds   = '0;
   logic [TILE_W-1:0] req_north       = '0;
   logic [TILE_W-1:0] req_north_east  = '0;
   logic [TILE_W-1:0] req_east        = '0;
   logic [TILE_W-1:0] req_south_east  = '0;
   logic [TILE_W-1:0] req_south       = '0;
   logic [TILE_W-1:0] req_south_west  = '0;
   logic [TILE_W-1:0] req_west        = '0;
   logic [TILE_W-1:0] req_north_west  = '0;
   logic              rsp_valid;
   logic              rsp_ready       = 1'b0;
   logic [MASK_W-1:0] rsp_mask;
   logic [TILE_W-1:0] rsp_chosen_tile;
   logic              rsp_tile_found;

   blob_neighbor_mask_tile_lookup dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_load_index  (req_load_index),
      .req_load_value  (req_load_value),
      .req_in_bounds   (req_in_bounds),
      .req_north       (req_north),
      .req_north_east  (req_north_east),
      .req_east        (req_east),
      .req_south_east  (req_south_east),
      .req_south       (req_south),
      .req_south_west  (req_south_west),
      .req_west        (req_west),
      .req_north_west  (req_north_west),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_mask        (rsp_mask),
      .rsp_chosen_tile (rsp_chosen_tile),
      .rsp_tile_found  (rsp_tile_found)
   );

   tile_lookup_scoreboard sb = new();

   // idling knobs, set per phase by the main sequence
   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;

   // long hold-off handshake: main bumps hold_asks, receiver serves it
   int unsigned hold_asks   = 0;
   int unsigned hold_served = 0;
   int unsigned hold_left   = 0;

   int unsigned cycle_count = 0;

   always begin
      #CLK_HALF_NS clock = 1'b1;
      #CLK_HALF_NS clock = 1'b0;
   end

   // Watchdog. The slowest legal run is well under a tenth of this.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d lookups still pending",
                  cycle_count, sb.expected_q.size());
         $display("tb_blob_neighbor_mask_tile_lookup NOT OK");
         $finish;
      end
   end

   // Response side: random stalls, plus one long stretch on request. The hold
   // is counted here so it runs regardless of what the sender is doing.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_asks != hold_served) begin
         rsp_ready   <= 1'b0;
         hold_served <= hold_asks;
         hold_left   <= LONG_HOLD;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Values sampled here are the pre-edge values, so this agrees with the DUT.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response({rsp_mask, rsp_chosen_tile, rsp_tile_found});
   end

   // -------------------------------------------------------------------------
   // Beat builders. Fields a beat does not use still carry random values.
   // -------------------------------------------------------------------------
   function automatic tile_req_type blank_beat();
      tile_req_type b;
      b.op         = bnm_pkg::OP_COMPUTE;
      b.load_index = TILE_W'($urandom_range(TILE_COUNT-1));
      b.load_value = TILE_W'($urandom_range(TILE_COUNT-1));
      b.in_bounds  = MASK_W'($urandom_range(255));
      for (int d = 0; d < DIR_COUNT; d++)
         b.nbr[d] = TILE_W'($urandom_range(TILE_COUNT-1));
      return b;
   endfunction

   function automatic tile_req_type load_beat(logic [2:0] op, logic [TILE_W-1:0] idx,
                                              logic [TILE_W-1:0] val);
      tile_req_type b = blank_beat();
      b.op         = op;
      b.load_index = idx;
      b.load_value = val;
      return b;
   endfunction

   // even directions (edges) get edge_id, odd ones (corners) get corner_id
   function automatic tile_req_type lookup_beat(logic [MASK_W-1:0] bounds,
                                                logic [TILE_W-1:0] edge_id,
                                                logic [TILE_W-1:0] corner_id);
      tile_req_type b = blank_beat();
      b.in_bounds = bounds;
      for (int d = 0; d < DIR_COUNT; d++)
         b.nbr[d] = d[0] ? corner_id : edge_id;
      return b;
   endfunction

   // Group ids: 0..31 and 992..1023, so both ends of the id range get members.
   function automatic logic [TILE_W-1:0] group_id();
      logic [TILE_W-1:0] id = TILE_W'($urandom_range(31));
      if ($urandom_range(1))
         id = id | 10'h3E0;
      return id;
   endfunction

   // Mostly lookups over a well-populated group; loads keep reshaping state.
   function automatic tile_req_type random_beat();
      tile_req_type      b;
      int unsigned       pick = $urandom_range(99);
      int unsigned       where = $urandom_range(99);
      logic [TILE_W-1:0] idx;
      logic [TILE_W-1:0] val = TILE_W'($urandom_range(TILE_COUNT-1));
      if (where < 5)
         idx = TILE_W'($urandom_range(TILE_COUNT-1, TABLE_DEPTH));   // off the map
      else if (where < 15)
         idx = FULL_IDX;
      else
         idx = TILE_W'($urandom_range(TABLE_DEPTH-1));
      if (pick < 12) begin
         val[0] = ($urandom_range(99) < 80);
         b = load_beat(bnm_pkg::OP_MEMBER,
                       ($urandom_range(99) < 70) ? group_id() : val ^ idx, val);
      end else if (pick < 24) begin
         b = load_beat(bnm_pkg::OP_TABLE_WR, idx, val);
      end else if (pick < 29) begin
         b = load_beat(bnm_pkg::OP_TABLE_INV, idx, val);
      end else if (pick < 32) begin
         b = load_beat(3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST)), idx, val);
      end else begin
         b = blank_beat();
         if ($urandom_range(99) < 70)
            b.in_bounds = '1;
         for (int d = 0; d < DIR_COUNT; d++)
            if ($urandom_range(99) < 75)
               b.nbr[d] = group_id();
      end
      return b;
   endfunction

   // -------------------------------------------------------------------------
   // Sender. Optional idle cycles first, then hold the beat until accepted.
   // Acceptance is noted here, in the same step, so the pending count seen by
   // the main sequence is never stale.
   // -------------------------------------------------------------------------
   task automatic send_beat(tile_req_type b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_operation   <= b.op;
      req_load_index  <= b.load_index;
      req_load_value  <= b.load_value;
      req_in_bounds   <= b.in_bounds;
      req_north       <= b.nbr[0];
      req_north_east  <= b.nbr[1];
      req_east        <= b.nbr[2];
      req_south_east  <= b.nbr[3];
      req_south       <= b.nbr[4];
      req_south_west  <= b.nbr[5];
      req_west        <= b.nbr[6];
      req_north_west  <= b.nbr[7];
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      sb.note_request(b);
   endtask

   // Sender pause: nothing offered until every pending lookup has answered.
   task automatic drain_lookups();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_q.size() != 0)
         @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      tile_req_type b;
      int unsigned  sent;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      // req_ready stays low through the member clearing sweep; send_beat waits

      for (int stage = 0; stage < 4; stage++) begin
         case (stage)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 69; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 69; end
            default: begin send_idle_pct = 13; rsp_stall_pct = 13; end
         endcase

         if (stage == 0) begin
            // fresh out of reset: nothing is a member, map is empty
            send_beat(lookup_beat(8'hFF, 10'd0, 10'd0));
            send_beat(load_beat(bnm_pkg::OP_MEMBER, 10'd0, 10'h3FF));
            send_beat(load_beat(bnm_pkg::OP_MEMBER, 10'h3FF, 10'd1));
            send_beat(load_beat(bnm_pkg::OP_MEMBER, 10'd5, 10'd1));
            // full mask, but the map is still empty
            send_beat(lookup_beat(8'hFF, 10'd0, 10'h3FF));
            send_beat(load_beat(bnm_pkg::OP_TABLE_WR, FULL_IDX, 10'h3FF));
            send_beat(load_beat(bnm_pkg::OP_TABLE_WR, 10'd0, 10'd0));
            // index past the map: must be dropped
            send_beat(load_beat(bnm_pkg::OP_TABLE_WR, 10'h3FF, 10'd77));
            // no neighbor is a member: mask 0, exact hit on tile 0
            send_beat(lookup_beat(8'hFF, 10'd100, 10'd100));
            // edges only -> mask 0x55, unmapped, falls back to full-mask entry
            send_beat(lookup_beat(8'hFF, 10'd5, 10'd100));
            // corners are members but have no edges next to them
            send_beat(lookup_beat(8'hFF, 10'd100, 10'h3FF));
            // everything off the map
            send_beat(lookup_beat(8'h00, 10'd0, 10'd0));
            // only the corner positions are on the map
            send_beat(lookup_beat(8'hAA, 10'd0, 10'd0));
            // n, ne, e
            send_beat(lookup_beat(8'h07, 10'd5, 10'd5));
            send_beat(load_beat(bnm_pkg::OP_TABLE_INV, FULL_IDX, 10'd0));
            // same lookup: no exact entry and no fallback any more
            send_beat(lookup_beat(8'h07, 10'd5, 10'd5));
            send_beat(load_beat(bnm_pkg::OP_TABLE_INV, 10'd0, 10'd0));
            send_beat(lookup_beat(8'hFF, 10'd100, 10'd100));
            send_beat(load_beat(bnm_pkg::OP_TABLE_WR, 10'd0, 10'd512));
            // flag bit clear with every other bit set: id 0 leaves the group
            send_beat(load_beat(bnm_pkg::OP_MEMBER, 10'd0, 10'h3FE));
            send_beat(lookup_beat(8'hFF, 10'd0, 10'd0));
            // spare codes: a decoder that drops bit 2 would act on these
            send_beat(load_beat(OP_SPARE_FIRST, 10'd0, 10'd1));
            send_beat(load_beat(OP_SPARE_LAST, 10'h3FF, 10'd0));
            send_beat(load_beat(bnm_pkg::OP_TABLE_INV, 10'h100, 10'd0));
            // fallback entry rewritten after invalidate
            send_beat(load_beat(bnm_pkg::OP_TABLE_WR, FULL_IDX, 10'h155));
            send_beat(lookup_beat(8'hFF, 10'h3FF, 10'd0));
            drain_lookups();

            // long response stall while the sender keeps pushing back to back
            hold_asks++;
         end

         sent = 0;
         while (sent < RANDOM_BEATS) begin
            b = random_beat();
            send_beat(b);
            if (b.op <= bnm_pkg::OP_COMPUTE)
               sent++;
         end
         drain_lookups();
      end

      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Run covered %0d request beats in four idling phases and %0d lookups.",
               sb.beats, sb.lookups);
      $display("Lookups: %0d exact map hits, %0d full-mask fallbacks, %0d not found.",
               sb.hits_exact, sb.hits_fallback, sb.misses);
      if (sb.mismatches == 0)
         $display("tb_blob_neighbor_mask_tile_lookup OK");
      else
         $display("tb_blob_neighbor_mask_tile_lookup NOT OK");
      $finish;
   end

endmodule
